[hw/rtl/epv_pkg.sv]
// shared types, constants and helpers for the encoder position and velocity estimator
`timescale 1ns / 1ps

package epv_pkg;

  // field widths
  localparam int RAW_W   = 32;
  localparam int IVL_W   = 20;
  localparam int ALPHA_W = 17;
  localparam int SCALE_W = 24;
  localparam int POS_W   = 48;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  // datapath sizing
  localparam int ACC_W   = 70;
  localparam int MUL_W   = 24;
  localparam int QUO_W   = 48;
  localparam int ITER_W  = 6;

  // fixed point
  localparam int SCALE_FRAC        = 24;
  localparam int ALPHA_FRAC        = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // counts per second over microseconds
  localparam int                 K_W      = 20;
  localparam logic [K_W-1:0]     US_PER_S = 20'd1000000;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // register reset values
  localparam logic [RAW_W-1:0]   HOME_COUNT_RST   = '0;
  localparam logic               DIRECTION_RST    = 1'b0;
  localparam logic [ALPHA_W-1:0] ALPHA_RST        = 17'd13107;
  localparam logic [SCALE_W-1:0] SCALE_RST        = 24'd83886;
  localparam logic [IVL_W-1:0]   MIN_INTERVAL_RST = 20'd100;

  typedef enum logic [IDX_W-1:0] {
    REG_HOME_COUNT   = 3'd0,
    REG_DIRECTION    = 3'd1,
    REG_ALPHA        = 3'd2,
    REG_SCALE        = 3'd3,
    REG_MIN_INTERVAL = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0]   home_count;
    logic               direction_negative;
    logic [ALPHA_W-1:0] alpha_q16;
    logic [SCALE_W-1:0] mm_per_count_q24;
    logic [IVL_W-1:0]   min_interval_us;
  } cfg_t;

  // request to the shared adder: a + b, or a - b when sub is set
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_req_t;

  // clamp a wide signed value to 48 signed bits
  function automatic logic [POS_W-1:0] sat48(input logic [ACC_W-1:0] x);
    logic [ACC_W-POS_W:0] top;
    logic [POS_W-1:0]     res;
    top = x[ACC_W-1:POS_W-1];
    if (&top || ~|top) begin
      res = x[POS_W-1:0];
    end else if (x[ACC_W-1]) begin
      res = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

[hw/rtl/epv_alu.sv]
// shared add/subtract unit used by every step of the estimator
`timescale 1ns / 1ps

module epv_alu (
  input  epv_pkg::alu_req_t             req,
  output logic [epv_pkg::ACC_W-1:0]     sum
);
  import epv_pkg::*;

  logic [ACC_W-1:0] b_op;

  always_comb begin
    b_op = req.sub ? ~req.b : req.b;
    sum  = req.a + b_op + ACC_W'(req.sub);
  end

endmodule

[hw/rtl/epv_engine.sv]
// sequencer and datapath registers of the estimator around the shared adder
`timescale 1ns / 1ps

module epv_engine #(
  parameter int FRACTION_BITS = epv_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         idle,
  input  logic [epv_pkg::RAW_W-1:0]    enc_count,
  input  logic [epv_pkg::IVL_W-1:0]    interval_us,
  input  logic                         restart,
  input  epv_pkg::cfg_t                cfg,
  output logic                         res_valid,
  input  logic                         res_take,
  output logic [epv_pkg::POS_W-1:0]    res_position,
  output logic [epv_pkg::POS_W-1:0]    res_velocity
);
  import epv_pkg::*;

  localparam int POS_SHIFT = SCALE_FRAC - FRACTION_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NET, ST_NEG, ST_PMUL, ST_POS, ST_DIFF, ST_MAG, ST_KMUL,
    ST_DCHK, ST_DIV, ST_INST, ST_EDIF, ST_EMUL, ST_EFIN, ST_FIN
  } state_t;

  state_t             state_r;
  logic [ITER_W-1:0]  cnt_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   opnd_r;
  logic [MUL_W-1:0]   mult_r;
  logic [IVL_W-1:0]   rem_r;
  logic               neg_r;
  logic [RAW_W-1:0]   raw_r;
  logic [IVL_W-1:0]   ivl_r;
  logic               restart_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   vel_r;
  logic [POS_W-1:0]   prev_r;
  logic [POS_W-1:0]   smooth_r;
  logic               primed_r;

  alu_req_t           req;
  logic [ACC_W-1:0]   sum;
  logic               sum_neg;
  logic [POS_W-1:0]   pos_calc;
  logic [POS_W-1:0]   vel_calc;
  logic [POS_W-1:0]   mag_c;
  logic [ALPHA_W-1:0] alpha_eff;
  logic               mul_step;

  epv_alu u_alu (
    .req (req),
    .sum (sum)
  );

  assign sum_neg   = sum[ACC_W-1];
  assign pos_calc  = sat48(ACC_W'($signed(acc_r) >>> POS_SHIFT));
  assign vel_calc  = sat48(ACC_W'($signed(acc_r) >>> ALPHA_FRAC));
  // weights above one act as one
  assign alpha_eff = cfg.alpha_q16[ALPHA_W-1] ? ALPHA_ONE : cfg.alpha_q16;
  assign mul_step  = (state_r == ST_PMUL) || (state_r == ST_KMUL) || (state_r == ST_EMUL);

  // rate clamp: 2^47 on the negative side, 2^47-1 on the positive side
  always_comb begin
    if (acc_r[QUO_W-1]) begin
      mag_c = neg_r ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
    end else begin
      mag_c = acc_r[QUO_W-1:0];
    end
  end

  always_comb begin
    req.a   = acc_r;
    req.b   = '0;
    req.sub = 1'b0;
    unique case (state_r)
      ST_NET: begin
        req.a   = ACC_W'($signed(raw_r));
        req.b   = ACC_W'($signed(cfg.home_count));
        req.sub = 1'b1;
      end
      ST_NEG: begin
        req.a   = '0;
        req.b   = opnd_r;
        req.sub = 1'b1;
      end
      ST_PMUL, ST_KMUL, ST_EMUL: begin
        req.b = mult_r[0] ? opnd_r : '0;
      end
      ST_DIFF: begin
        req.a   = ACC_W'($signed(pos_r));
        req.b   = ACC_W'($signed(prev_r));
        req.sub = 1'b1;
      end
      ST_MAG: begin
        req.a   = '0;
        req.b   = acc_r;
        req.sub = 1'b1;
      end
      ST_DCHK: begin
        req.a   = ACC_W'(acc_r[ACC_W-1:QUO_W]);
        req.b   = ACC_W'(ivl_r);
        req.sub = 1'b1;
      end
      ST_DIV: begin
        req.a   = ACC_W'({rem_r, acc_r[QUO_W-1]});
        req.b   = ACC_W'(ivl_r);
        req.sub = 1'b1;
      end
      ST_INST: begin
        req.a   = '0;
        req.b   = ACC_W'(mag_c);
        req.sub = 1'b1;
      end
      ST_EDIF: begin
        req.a   = acc_r;
        req.b   = ACC_W'($signed(smooth_r));
        req.sub = 1'b1;
      end
      default: begin
        req.a   = acc_r;
        req.b   = '0;
        req.sub = 1'b0;
      end
    endcase
  end

  assign idle         = (state_r == ST_IDLE);
  assign res_valid    = (state_r == ST_FIN);
  assign res_position = pos_r;
  assign res_velocity = vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      primed_r <= 1'b0;
      prev_r   <= '0;
      smooth_r <= '0;
    end else begin
      // shift-add multiply step
      if (mul_step) begin
        acc_r  <= sum;
        opnd_r <= {opnd_r[ACC_W-2:0], 1'b0};
        mult_r <= {1'b0, mult_r[MUL_W-1:1]};
        cnt_r  <= cnt_r - 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            raw_r     <= enc_count;
            ivl_r     <= interval_us;
            restart_r <= restart;
            state_r   <= ST_NET;
          end
        end
        ST_NET: begin
          opnd_r  <= ACC_W'($signed(sum[RAW_W-1:0]));
          state_r <= ST_NEG;
        end
        ST_NEG: begin
          if (cfg.direction_negative) begin
            opnd_r <= sum;
          end
          acc_r   <= '0;
          mult_r  <= MUL_W'(cfg.mm_per_count_q24);
          cnt_r   <= ITER_W'(SCALE_W - 1);
          state_r <= ST_PMUL;
        end
        ST_PMUL: begin
          if (cnt_r == '0) begin
            state_r <= ST_POS;
          end
        end
        ST_POS: begin
          pos_r <= pos_calc;
          if (!primed_r || restart_r) begin
            primed_r <= 1'b1;
            prev_r   <= pos_calc;
            smooth_r <= '0;
            vel_r    <= '0;
            state_r  <= ST_FIN;
          end else if (ivl_r <= cfg.min_interval_us) begin
            vel_r   <= smooth_r;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          acc_r   <= sum;
          neg_r   <= sum_neg;
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          opnd_r  <= neg_r ? sum : acc_r;
          acc_r   <= '0;
          mult_r  <= MUL_W'(US_PER_S);
          cnt_r   <= ITER_W'(K_W - 1);
          state_r <= ST_KMUL;
        end
        ST_KMUL: begin
          if (cnt_r == '0) begin
            state_r <= ST_DCHK;
          end
        end
        ST_DCHK: begin
          // quotient would reach 2^48: saturate without dividing
          if (!sum_neg) begin
            acc_r   <= ACC_W'({1'b1, {(QUO_W-1){1'b0}}});
            state_r <= ST_INST;
          end else begin
            rem_r   <= acc_r[QUO_W+IVL_W-1:QUO_W];
            acc_r   <= ACC_W'(acc_r[QUO_W-1:0]);
            cnt_r   <= ITER_W'(QUO_W - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          acc_r[QUO_W-1:0] <= {acc_r[QUO_W-2:0], ~sum_neg};
          rem_r            <= sum_neg ? {rem_r[IVL_W-2:0], acc_r[QUO_W-1]}
                                      : sum[IVL_W-1:0];
          cnt_r            <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_INST;
          end
        end
        ST_INST: begin
          acc_r   <= neg_r ? sum : ACC_W'(mag_c);
          state_r <= ST_EDIF;
        end
        ST_EDIF: begin
          // s*2^16 + a*(v - s)
          opnd_r  <= sum;
          acc_r   <= ACC_W'($signed(smooth_r)) << ALPHA_FRAC;
          mult_r  <= MUL_W'(alpha_eff);
          cnt_r   <= ITER_W'(ALPHA_W - 1);
          state_r <= ST_EMUL;
        end
        ST_EMUL: begin
          if (cnt_r == '0) begin
            state_r <= ST_EFIN;
          end
        end
        ST_EFIN: begin
          vel_r    <= vel_calc;
          smooth_r <= vel_calc;
          prev_r   <= pos_r;
          state_r  <= ST_FIN;
        end
        ST_FIN: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/encoder_position_velocity_ema_core.sv]
// top level of the encoder position and velocity estimator with moving-average filter
`timescale 1ns / 1ps

// Each word on the input carries an encoder count, the time since the previous
// sample in microseconds and a restart flag; each produces exactly one result
// word holding the position in signed Q.FRACTION_BITS millimetres and the
// filtered velocity in millimetres per second, both 48 bits and saturated.
// Position is the count minus the home count, wrapped to 32 bits, negated when
// direction_negative is set, times the Q0.24 scale. The first sample after
// reset, or any word with restart set, primes the estimator and reports
// velocity 0; an interval at or below the minimum interval reports the held
// filtered velocity and leaves the state alone. Otherwise the instantaneous
// rate (position change times 10^6 over the interval, truncated, clamped to
// 48 bits) feeds an exponential moving average weighted by alpha_q16.
// All arithmetic runs through one 70-bit adder under a sequencer: a 24-step
// shift-add multiply for position, a 20-step multiply by 10^6, a 48-step
// restoring divide and a 17-step multiply for the filter. The divide is
// skipped when the rate saturates; a priming or held-velocity sample skips
// every step after the position multiply. The input is ready only while the
// sequencer is idle, which starts the cycle after the result leaves it.
// Results sit in an output register, so the next word can be taken while the
// previous result waits for out_ready. Configuration writes are single-cycle
// and should only happen while the block is idle.

module encoder_position_velocity_ema_core #(
  parameter int FRACTION_BITS = epv_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  // configuration write port
  input  logic                              cfg_we,
  input  logic [epv_pkg::IDX_W-1:0]         cfg_index,
  input  logic [epv_pkg::CFG_W-1:0]         cfg_wdata,

  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [epv_pkg::RAW_W-1:0]  in_enc_count,
  input  logic [epv_pkg::IVL_W-1:0]         in_interval_us,
  input  logic                              in_restart,

  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [epv_pkg::POS_W-1:0]  out_position_mm_q16,
  output logic signed [epv_pkg::POS_W-1:0]  out_velocity_mm_s_q16
);
  import epv_pkg::*;

  cfg_t             cfg_r;
  logic             out_valid_r;
  logic [POS_W-1:0] out_pos_r;
  logic [POS_W-1:0] out_vel_r;

  logic             eng_idle;
  logic             res_valid;
  logic             res_take;
  logic [POS_W-1:0] res_position;
  logic [POS_W-1:0] res_velocity;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.home_count         <= HOME_COUNT_RST;
      cfg_r.direction_negative <= DIRECTION_RST;
      cfg_r.alpha_q16          <= ALPHA_RST;
      cfg_r.mm_per_count_q24   <= SCALE_RST;
      cfg_r.min_interval_us    <= MIN_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOME_COUNT:   cfg_r.home_count         <= cfg_wdata[RAW_W-1:0];
        REG_DIRECTION:    cfg_r.direction_negative <= cfg_wdata[0];
        REG_ALPHA:        cfg_r.alpha_q16          <= cfg_wdata[ALPHA_W-1:0];
        REG_SCALE:        cfg_r.mm_per_count_q24   <= cfg_wdata[SCALE_W-1:0];
        REG_MIN_INTERVAL: cfg_r.min_interval_us    <= cfg_wdata[IVL_W-1:0];
        default: begin
          // unused indexes are ignored
        end
      endcase
    end
  end

  // sequencer takes a word whenever it is idle
  assign in_ready = eng_idle;

  epv_engine #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_valid),
    .idle         (eng_idle),
    .enc_count    (in_enc_count),
    .interval_us  (in_interval_us),
    .restart      (in_restart),
    .cfg          (cfg_r),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res_position (res_position),
    .res_velocity (res_velocity)
  );

  // output register frees the sequencer once a result is handed over
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
      out_pos_r   <= res_position;
      out_vel_r   <= res_velocity;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_position_mm_q16   = out_pos_r;
  assign out_velocity_mm_s_q16 = out_vel_r;

endmodule

[dv/encoder_position_velocity_ema_core_tb.sv]
// self-checking testbench: directed and random encoder samples checked against a bit-true estimator
`timescale 1ns / 1ps

module encoder_position_velocity_ema_core_tb;
  import epv_pkg::*;

  localparam int     FRAC        = FRACTION_BITS_DEF;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     SHOW_FAULTS = 10;
  localparam longint VEL_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VEL_MIN     = -VEL_MAX - 1;
  localparam longint US_PER_SEC  = 1000000;
  localparam logic [IVL_W-1:0] IVL_MAX = {IVL_W{1'b1}};

  typedef struct packed {
    logic signed [RAW_W-1:0] enc_count;
    logic [IVL_W-1:0]        interval_us;
    logic                    restart;
  } sample_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] velocity;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [RAW_W-1:0] in_enc_count = '0;
  logic [IVL_W-1:0]        in_interval_us = '0;
  logic                    in_restart = 1'b0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] out_position_mm_q16;
  logic signed [POS_W-1:0] out_velocity_mm_s_q16;

  // words waiting to be offered, and results the estimator has predicted
  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];

  // shadow copy of the registers
  logic signed [RAW_W-1:0] shadow_home_count = HOME_COUNT_RST;
  logic                    shadow_direction_neg = DIRECTION_RST;
  logic [ALPHA_W-1:0]      shadow_alpha = ALPHA_RST;
  logic [SCALE_W-1:0]      shadow_scale = SCALE_RST;
  logic [IVL_W-1:0]        shadow_min_interval = MIN_INTERVAL_RST;

  // estimator state as the block should hold it
  logic   est_primed = 1'b0;
  longint est_last_pos = 0;
  longint est_filtered_vel = 0;

  // idling and long output stall control
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;

  int walk_count = 0;
  int cycle_count = 0;
  int fault_count = 0;
  int samples_accepted = 0;
  int results_checked = 0;
  int restarts_seen = 0;
  int holds_seen = 0;
  int cfg_writes = 0;

  encoder_position_velocity_ema_core #(
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_enc_count          (in_enc_count),
    .in_interval_us        (in_interval_us),
    .in_restart            (in_restart),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_position_mm_q16   (out_position_mm_q16),
    .out_velocity_mm_s_q16 (out_velocity_mm_s_q16)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // clamp to the signed 48-bit result range
  function automatic longint clamp_q48(input logic signed [79:0] x);
    if (x > VEL_MAX) return VEL_MAX;
    if (x < VEL_MIN) return VEL_MIN;
    return x[63:0];
  endfunction

  // position change times 10^6 over the interval, truncated toward zero
  function automatic longint rate_of_change(input longint diff, input logic [IVL_W-1:0] ivl);
    longint unsigned mag, q, r, res, lim;
    lim = 64'd1 << 47;
    mag = (diff < 0) ? -diff : diff;
    q = mag / ivl;
    r = mag % ivl;
    // quotient alone already past the 48-bit range
    if (q > lim / US_PER_SEC) res = lim;
    else res = q * US_PER_SEC + (r * US_PER_SEC) / ivl;
    if (diff < 0) return (res >= lim) ? VEL_MIN : -longint'(res);
    return (res >= lim) ? VEL_MAX : longint'(res);
  endfunction

  // one input word in, one predicted result out; advances the shadow estimator
  function automatic estimate_t estimate_sample(input sample_t s);
    logic [RAW_W-1:0]   net;
    longint             n, pos, vel, a, inst;
    logic signed [79:0] acc;
    estimate_t          e;
    // wrap the offset count to 32 bits before applying direction
    net = s.enc_count - shadow_home_count;
    n = $signed(net);
    if (shadow_direction_neg) n = -n;
    pos = clamp_q48((n * longint'(shadow_scale)) >>> (SCALE_FRAC - FRAC));
    if (s.restart) begin
      est_primed = 1'b0;
      est_last_pos = 0;
      est_filtered_vel = 0;
      restarts_seen++;
    end
    if (!est_primed) begin
      // first sample primes and reports zero velocity
      est_primed = 1'b1;
      est_last_pos = pos;
      est_filtered_vel = 0;
      vel = 0;
    end else if (s.interval_us <= shadow_min_interval) begin
      // short interval reports the held velocity, state untouched
      vel = est_filtered_vel;
      holds_seen++;
    end else begin
      // alpha above one acts as one
      a = (shadow_alpha > ALPHA_ONE) ? ALPHA_ONE : shadow_alpha;
      inst = rate_of_change(pos - est_last_pos, s.interval_us);
      acc = a * inst + (65536 - a) * est_filtered_vel;
      vel = clamp_q48(acc >>> ALPHA_FRAC);
      est_last_pos = pos;
      est_filtered_vel = vel;
    end
    e.position = pos[POS_W-1:0];
    e.velocity = vel[POS_W-1:0];
    return e;
  endfunction

  // driver: offers queued words, predicts each one as it is accepted
  always @(posedge clk) begin : driver
    sample_t cur;
    sample_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        cur.enc_count = in_enc_count;
        cur.interval_us = in_interval_us;
        cur.restart = in_restart;
        expected_estimates.push_back(estimate_sample(cur));
        samples_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_enc_count <= nxt.enc_count;
          in_interval_us <= nxt.interval_us;
          in_restart <= nxt.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output stall, counted down on its own
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served < holds_requested) begin
      hold_left <= hold_len;
      holds_served <= holds_served + 1;
    end
  end

  // monitor: random backpressure, each result against the oldest prediction
  always @(posedge clk) begin : monitor
    estimate_t want;
    out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_estimates.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOW_FAULTS)
          $display("unexpected result word: position %0d velocity %0d",
                   out_position_mm_q16, out_velocity_mm_s_q16);
      end else begin
        want = expected_estimates.pop_front();
        results_checked++;
        if (out_position_mm_q16 !== want.position || out_velocity_mm_s_q16 !== want.velocity) begin
          fault_count++;
          if (fault_count <= SHOW_FAULTS)
            $display("mismatch on result %0d: expected pos %0d vel %0d, got pos %0d vel %0d",
                     results_checked, $signed(want.position), $signed(want.velocity),
                     out_position_mm_q16, out_velocity_mm_s_q16);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_estimates.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HOME_COUNT:   shadow_home_count = val[RAW_W-1:0];
      REG_DIRECTION:    shadow_direction_neg = val[0];
      REG_ALPHA:        shadow_alpha = val[ALPHA_W-1:0];
      REG_SCALE:        shadow_scale = val[SCALE_W-1:0];
      REG_MIN_INTERVAL: shadow_min_interval = val[IVL_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] zero, input logic dir, input logic [16:0] alpha,
                            input logic [23:0] scale, input logic [19:0] min_ivl);
    write_reg(REG_HOME_COUNT, zero);
    write_reg(REG_DIRECTION, {31'd0, dir});
    write_reg(REG_ALPHA, {15'd0, alpha});
    write_reg(REG_SCALE, {8'd0, scale});
    write_reg(REG_MIN_INTERVAL, {12'd0, min_ivl});
  endtask

  task automatic offer(input logic [31:0] raw, input logic [19:0] ivl, input logic rs);
    sample_t s;
    s.enc_count = raw;
    s.interval_us = ivl;
    s.restart = rs;
    pending_samples.push_back(s);
  endtask

  // block fully drained: nothing queued, nothing offered, nothing expected
  task automatic wait_idle();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_estimates.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // mostly a plausible encoder walk, some short intervals, some raw noise
  task automatic queue_random(input int count, input int hold_cycles);
    int     kind, step;
    longint t;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) step = $signed($urandom) >>> 6;
      else step = int'($urandom_range(0, 4000)) - 2000;
      walk_count += step;
      if (kind < 75) begin
        t = longint'(shadow_min_interval) + 1 + $urandom_range(0, 20000);
        if (t > IVL_MAX) t = IVL_MAX;
        offer(walk_count, t[IVL_W-1:0], $urandom_range(0, 49) == 0);
      end else if (kind < 85) begin
        offer(walk_count, IVL_W'($urandom_range(0, shadow_min_interval)), 1'b0);
      end else begin
        offer($urandom, IVL_W'($urandom_range(0, IVL_MAX)), 1'($urandom_range(0, 1)));
      end
      // long receiver stall while words keep coming
      if (i == 20 && hold_cycles != 0) begin
        hold_len = hold_cycles;
        holds_requested++;
      end
      // sender pause until everything is back
      if (i % 50 == 49) wait_idle();
    end
  endtask

  initial begin
    send_idle_pct = 22;
    recv_idle_pct = 71;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: priming, normal update, held at and below the minimum
    offer(1000, 1000 / 2, 1'b0);
    offer(2000, 1000, 1'b0);
    offer(2500, 100, 1'b0);
    offer(2600, 0, 1'b0);
    offer(32'h8000_0000, IVL_MAX, 1'b0);
    offer(32'h7FFF_FFFF, 1, 1'b0);
    offer(32'h7FFF_FFFF, 101, 1'b0);
    offer(5, 0, 1'b1);
    offer(-5, 1000, 1'b0);
    wait_idle();

    // extreme offset and scale, unfiltered, zero minimum: rate saturates both ways
    set_config(32'h8000_0000, 1'b1, ALPHA_ONE, 24'hFF_FFFF, 20'd0);
    offer(0, 0, 1'b1);
    offer(32'h7FFF_FFFF, 1, 1'b0);
    offer(0, 1, 1'b0);
    offer(0, 0, 1'b0);
    wait_idle();

    // alpha above one
    write_reg(REG_ALPHA, 32'h1_FFFF);
    offer(1000, 50, 1'b0);
    offer(-3000, IVL_MAX, 1'b0);
    wait_idle();

    // alpha zero keeps the filter but still moves the reference position
    write_reg(REG_ALPHA, 32'd0);
    offer(7, 700, 1'b0);
    offer(123456, 1, 1'b0);
    wait_idle();

    // every interval at or below the minimum, zero scale
    set_config(32'h7FFF_FFFF, 1'b0, 17'd1, 24'd0, IVL_MAX);
    offer(32'h7FFF_FFFF, IVL_MAX, 1'b0);
    offer(-1, 0, 1'b0);
    offer(0, 5, 1'b1);
    wait_idle();

    // random, sender idles lightly, receiver heavily
    set_config($urandom, 1'b0, ALPHA_W'($urandom_range(1, 65536)),
               SCALE_W'($urandom_range(1, 24'hFF_FFFF)), IVL_W'($urandom_range(0, 1000)));
    queue_random(150, 500);
    wait_idle();

    // random, the other way round
    send_idle_pct = 71;
    recv_idle_pct = 22;
    set_config($urandom, 1'b1, ALPHA_W'($urandom_range(1, 17'h1_FFFF)),
               SCALE_W'($urandom_range(0, 20'hF_FFFF)), IVL_W'($urandom_range(0, 3000)));
    queue_random(150, 0);
    wait_idle();

    // random, back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config($urandom, 1'($urandom_range(0, 1)), ALPHA_W'($urandom_range(1, 65536)),
               SCALE_W'($urandom), IVL_W'($urandom_range(0, 500)));
    queue_random(150, 300);
    wait_idle();

    // catch any stray result after the last one
    repeat (200) @(negedge clk);
    if (expected_estimates.size() != 0) fault_count++;

    $display("checked %0d results from %0d words: %0d restarts, %0d held intervals, %0d writes",
             results_checked, samples_accepted, restarts_seen, holds_seen, cfg_writes);
    $display("three idle patterns, %0d long output stalls, %0d faults",
             holds_served, fault_count);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
